@@ rtl/core/gpw_pkg.sv @@
// Guest page walker package: walk state and result types, field codes,
// address constants. No dependencies.
package gpw_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned BYTES_W = 4;
    localparam int unsigned CFG_IDX_W = 2;

    // request types on the input channel
    localparam logic REQ_TRANSLATE = 1'b0;
    localparam logic REQ_ENTRY     = 1'b1;

    // result kinds on the output channel
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGING_ON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAE_ON    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ROOT = 2'd2;

    // walk levels: table whose entry is awaited
    localparam logic [1:0] LVL_ROOT = 2'd0;
    localparam logic [1:0] LVL_MID  = 2'd1;
    localparam logic [1:0] LVL_LEAF = 2'd2;

    localparam logic [ADDR_W-1:0] NOT_MAPPED = 32'hFFFF_FFFF;
    localparam logic [BYTES_W-1:0] ENTRY_BYTES_PAE    = 4'd8;
    localparam logic [BYTES_W-1:0] ENTRY_BYTES_LEGACY = 4'd4;

    localparam int unsigned PRESENT_BIT = 0;
    localparam int unsigned PS_BIT      = 7;

    typedef struct packed {
        logic              busy;
        logic [1:0]        level;
        logic [ADDR_W-1:0] held;
    } walk_state_t;

    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] bytes;
        logic               fault;
    } result_t;

endpackage

@@ rtl/core/gpw_step.sv @@
// One walk step: decodes a translate request or an entry response against
// the walk state. Pure combinational logic; uses gpw_pkg.
module gpw_step (
    input  logic                       req_type,
    input  logic [gpw_pkg::ADDR_W-1:0] virtual_address,
    input  logic [gpw_pkg::ADDR_W-1:0] entry_data,
    input  logic                       paging_on,
    input  logic                       pae_on,
    input  logic [gpw_pkg::ADDR_W-1:0] table_root,
    input  gpw_pkg::walk_state_t       walk_cur,
    output gpw_pkg::walk_state_t       walk_nxt,
    output gpw_pkg::result_t           res,
    output logic                       res_valid
);

    logic [gpw_pkg::ADDR_W-1:0] va;
    logic [gpw_pkg::ADDR_W-1:0] e;

    assign e = entry_data;

    always_comb begin
        walk_nxt  = walk_cur;
        res_valid = 1'b0;
        res.kind  = gpw_pkg::KIND_DONE;
        res.addr  = '0;
        res.fault = 1'b0;
        res.bytes = pae_on ? gpw_pkg::ENTRY_BYTES_PAE : gpw_pkg::ENTRY_BYTES_LEGACY;
        va        = walk_cur.held;

        if (req_type == gpw_pkg::REQ_TRANSLATE) begin
            va            = virtual_address;
            walk_nxt.held = virtual_address;
            res_valid     = 1'b1;
            if (!paging_on) begin
                walk_nxt.busy  = 1'b0;
                walk_nxt.level = gpw_pkg::LVL_ROOT;
                res.addr       = va;
            end else begin
                walk_nxt.busy  = 1'b1;
                walk_nxt.level = gpw_pkg::LVL_ROOT;
                res.kind       = gpw_pkg::KIND_READ;
                if (pae_on) begin
                    res.addr = {table_root[31:5], va[31:30], 3'b000};
                end else begin
                    res.addr = {table_root[31:12], va[31:22], 2'b00};
                end
            end
        end else if (walk_cur.busy) begin
            res_valid = 1'b1;
            // finish by default; the read-request arms below override
            walk_nxt.busy  = 1'b0;
            walk_nxt.level = gpw_pkg::LVL_ROOT;
            if (!e[gpw_pkg::PRESENT_BIT]) begin
                res.addr  = gpw_pkg::NOT_MAPPED;
                res.fault = 1'b1;
            end else if (pae_on) begin
                if (walk_cur.level == gpw_pkg::LVL_ROOT) begin
                    walk_nxt.busy  = 1'b1;
                    walk_nxt.level = gpw_pkg::LVL_MID;
                    res.kind       = gpw_pkg::KIND_READ;
                    res.addr       = {e[31:12], va[29:21], 3'b000};
                end else if (walk_cur.level == gpw_pkg::LVL_MID) begin
                    if (e[gpw_pkg::PS_BIT]) begin
                        res.addr = {e[31:21], va[20:0]};
                    end else begin
                        walk_nxt.busy  = 1'b1;
                        walk_nxt.level = gpw_pkg::LVL_LEAF;
                        res.kind       = gpw_pkg::KIND_READ;
                        res.addr       = {e[31:12], va[20:12], 3'b000};
                    end
                end else begin
                    res.addr = {e[31:12], va[11:0]};
                end
            end else begin
                if (walk_cur.level == gpw_pkg::LVL_ROOT) begin
                    if (e[gpw_pkg::PS_BIT]) begin
                        res.addr = {e[31:22], va[21:0]};
                    end else begin
                        walk_nxt.busy  = 1'b1;
                        walk_nxt.level = gpw_pkg::LVL_MID;
                        res.kind       = gpw_pkg::KIND_READ;
                        res.addr       = {e[31:12], va[21:12], 2'b00};
                    end
                end else begin
                    res.addr = {e[31:12], va[11:0]};
                end
            end
        end
    end

endmodule

@@ rtl/core/gpw_out_stage.sv @@
// Result register of the walker: holds one result beat until the consumer
// takes it. Uses gpw_pkg types.
module gpw_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  gpw_pkg::result_t res,
    input  logic             m_ready,
    output logic             free,
    output logic             m_valid,
    output gpw_pkg::result_t m_res
);

    logic             valid_reg;
    logic             valid_next;
    gpw_pkg::result_t res_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

@@ rtl/core/x86_guest_page_walker.sv @@
// Guest page walker top level: input register, walk state, config registers,
// step logic and result register. Uses gpw_pkg, gpw_step, gpw_out_stage.
//
//  channel | ports                                     | role
//  --------+-------------------------------------------+----------------------------
//  s_      | s_valid s_ready s_req_type s_virtual_...  | translate requests, entries
//  m_      | m_valid m_ready m_result_kind m_out_...   | entry reads, walk results
//  cfg_    | cfg_wr_en cfg_index cfg_wdata             | paging_on, pae_on, table_root
//
// Each beat is held in the input register and decoded against the walk state
// while it sits there; its result is then captured in the result register, and
// one beat is taken per cycle while the result register is not stalled.
// Throughput is set by the result register: a stalled result holds the input
// register, which then holds s_ready low. Reset is synchronous and clears the
// walk state and configuration; no clearing pass is needed.
module x86_guest_page_walker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [gpw_pkg::ADDR_W-1:0]  s_virtual_address,
    input  logic [gpw_pkg::ADDR_W-1:0]  s_entry_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_result_kind,
    output logic [gpw_pkg::ADDR_W-1:0]  m_out_address,
    output logic [gpw_pkg::BYTES_W-1:0] m_entry_bytes,
    output logic                        m_fault,
    input  logic                        cfg_wr_en,
    input  logic [gpw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gpw_pkg::ADDR_W-1:0]  cfg_wdata
);

    logic                       paging_on_reg;
    logic                       pae_on_reg;
    logic [gpw_pkg::ADDR_W-1:0] table_root_reg;

    logic                       in_valid_reg;
    logic                       in_type_reg;
    logic [gpw_pkg::ADDR_W-1:0] in_va_reg;
    logic [gpw_pkg::ADDR_W-1:0] in_entry_reg;

    gpw_pkg::walk_state_t walk_reg;
    gpw_pkg::walk_state_t walk_next;
    gpw_pkg::result_t     step_res;
    gpw_pkg::result_t     m_res;
    logic                 step_valid;
    logic                 out_free;
    logic                 advance;
    logic                 s_take;

    assign advance = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            paging_on_reg  <= 1'b0;
            pae_on_reg     <= 1'b0;
            table_root_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gpw_pkg::CFG_PAGING_ON:  paging_on_reg  <= cfg_wdata[0];
                gpw_pkg::CFG_PAE_ON:     pae_on_reg     <= cfg_wdata[0];
                gpw_pkg::CFG_TABLE_ROOT: table_root_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_type_reg  <= s_req_type;
            in_va_reg    <= s_virtual_address;
            in_entry_reg <= s_entry_data;
        end
    end

    // advance the walk state once per beat leaving the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg <= '0;
        end else if (advance) begin
            walk_reg <= walk_next;
        end
    end

    gpw_step u_step (
        .req_type        (in_type_reg),
        .virtual_address (in_va_reg),
        .entry_data      (in_entry_reg),
        .paging_on       (paging_on_reg),
        .pae_on          (pae_on_reg),
        .table_root      (table_root_reg),
        .walk_cur        (walk_reg),
        .walk_nxt        (walk_next),
        .res             (step_res),
        .res_valid       (step_valid)
    );

    gpw_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && step_valid),
        .res     (step_res),
        .m_ready (m_ready),
        .free    (out_free),
        .m_valid (m_valid),
        .m_res   (m_res)
    );

    assign m_result_kind = m_res.kind;
    assign m_out_address = m_res.addr;
    assign m_entry_bytes = m_res.bytes;
    assign m_fault       = m_res.fault;

    a_read_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == gpw_pkg::KIND_READ) |-> !m_fault)
        else $error("entry read request carries a fault");

    a_idle_level: assert property (@(posedge aclk) disable iff (!aresetn)
        !walk_reg.busy |-> (walk_reg.level == gpw_pkg::LVL_ROOT))
        else $error("idle walk with nonzero level");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_reg.level != 2'd3)
        else $error("walk level out of range");

    a_idle_entry_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_type_reg == gpw_pkg::REQ_ENTRY) && !walk_reg.busy
        |=> m_valid == $past(m_valid && !m_ready))
        else $error("entry response while idle produced a result");

endmodule

@@ dv/x86_guest_page_walker_tb.sv @@
`timescale 1ns / 1ps
// Testbench for x86_guest_page_walker: directed and random page walks checked against
// an in-bench walk predictor. Depends on gpw_pkg and the walker RTL only.
module x86_guest_page_walker_tb;

    localparam int DRAIN_CYCLES = 6;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_req_type = gpw_pkg::REQ_TRANSLATE;
    logic [gpw_pkg::ADDR_W-1:0]    s_virtual_address = '0;
    logic [gpw_pkg::ADDR_W-1:0]    s_entry_data = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_result_kind;
    logic [gpw_pkg::ADDR_W-1:0]    m_out_address;
    logic [gpw_pkg::BYTES_W-1:0]   m_entry_bytes;
    logic                          m_fault;
    logic                          cfg_wr_en = 1'b0;
    logic [gpw_pkg::CFG_IDX_W-1:0] cfg_index = gpw_pkg::CFG_PAGING_ON;
    logic [gpw_pkg::ADDR_W-1:0]    cfg_wdata = '0;

    // predictor copy of configuration and walk state
    logic                       cfg_paging = 1'b0;
    logic                       cfg_pae = 1'b0;
    logic [gpw_pkg::ADDR_W-1:0] cfg_root = '0;
    logic                       walk_busy = 1'b0;
    logic [1:0]                 walk_level = gpw_pkg::LVL_ROOT;
    logic [gpw_pkg::ADDR_W-1:0] walk_va = '0;

    gpw_pkg::result_t expected_walk_results[$];

    int tx_idle_pct = 8;
    int rx_idle_pct = 55;
    int mismatch_count = 0;
    int live_beats = 0;
    int ignored_beats = 0;
    int results_checked = 0;
    int walks_done = 0;
    int faults_seen = 0;
    int configs_loaded = 0;

    x86_guest_page_walker i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_virtual_address (s_virtual_address),
        .s_entry_data      (s_entry_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_out_address     (m_out_address),
        .m_entry_bytes     (m_entry_bytes),
        .m_fault           (m_fault),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic queue_result(input logic kind, input logic [gpw_pkg::ADDR_W-1:0] addr,
                                input logic fault);
        gpw_pkg::result_t r;
        r.kind  = kind;
        r.addr  = addr;
        r.bytes = cfg_pae ? gpw_pkg::ENTRY_BYTES_PAE : gpw_pkg::ENTRY_BYTES_LEGACY;
        r.fault = fault;
        expected_walk_results.push_back(r);
    endtask

    task automatic finish_walk(input logic [gpw_pkg::ADDR_W-1:0] addr, input logic fault);
        walk_busy  = 1'b0;
        walk_level = gpw_pkg::LVL_ROOT;
        walks_done++;
        if (fault) faults_seen++;
        queue_result(gpw_pkg::KIND_DONE, addr, fault);
    endtask

    task automatic request_entry(input logic [1:0] lvl,
                                 input logic [gpw_pkg::ADDR_W-1:0] addr);
        walk_busy  = 1'b1;
        walk_level = lvl;
        queue_result(gpw_pkg::KIND_READ, addr, 1'b0);
    endtask

    // Work out what one accepted beat produces, using the current mode
    task automatic predict_walk(input logic rtype, input logic [gpw_pkg::ADDR_W-1:0] va,
                                input logic [gpw_pkg::ADDR_W-1:0] ent);
        if (rtype == gpw_pkg::REQ_TRANSLATE) begin
            live_beats++;
            walk_va = va;
            if (!cfg_paging)
                finish_walk(va, 1'b0);
            else if (cfg_pae)
                request_entry(gpw_pkg::LVL_ROOT, {cfg_root[31:5], va[31:30], 3'b000});
            else
                request_entry(gpw_pkg::LVL_ROOT, {cfg_root[31:12], va[31:22], 2'b00});
        end else if (!walk_busy) begin
            ignored_beats++;
        end else begin
            live_beats++;
            if (!ent[gpw_pkg::PRESENT_BIT]) begin
                finish_walk(gpw_pkg::NOT_MAPPED, 1'b1);
            end else if (cfg_pae) begin
                if (walk_level == gpw_pkg::LVL_ROOT)
                    request_entry(gpw_pkg::LVL_MID,
                                  {ent[31:12], walk_va[29:21], 3'b000});
                else if (walk_level == gpw_pkg::LVL_MID && ent[gpw_pkg::PS_BIT])
                    finish_walk({ent[31:21], walk_va[20:0]}, 1'b0);
                else if (walk_level == gpw_pkg::LVL_MID)
                    request_entry(gpw_pkg::LVL_LEAF,
                                  {ent[31:12], walk_va[20:12], 3'b000});
                else
                    finish_walk({ent[31:12], walk_va[11:0]}, 1'b0);
            end else if (walk_level == gpw_pkg::LVL_ROOT) begin
                if (ent[gpw_pkg::PS_BIT])
                    finish_walk({ent[31:22], walk_va[21:0]}, 1'b0);
                else
                    request_entry(gpw_pkg::LVL_MID, {ent[31:12], walk_va[21:12], 2'b00});
            end else begin
                // any deeper level is the page table in legacy mode
                finish_walk({ent[31:12], walk_va[11:0]}, 1'b0);
            end
        end
    endtask

    task automatic flag_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Sample at the falling edge: a beat seen here is taken at the next rising edge
    always @(negedge aclk) begin
        gpw_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_walk_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result addr %h", m_out_address));
            end else begin
                want = expected_walk_results.pop_front();
                if (m_result_kind !== want.kind)
                    flag_mismatch($sformatf("kind %b, want %b", m_result_kind, want.kind));
                if (m_out_address !== want.addr)
                    flag_mismatch($sformatf("address %h, want %h", m_out_address, want.addr));
                if (m_entry_bytes !== want.bytes)
                    flag_mismatch($sformatf("entry bytes %0d, want %0d",
                                            m_entry_bytes, want.bytes));
                if (m_fault !== want.fault)
                    flag_mismatch($sformatf("fault %b, want %b", m_fault, want.fault));
            end
        end
    end

    task automatic send_beat(input logic rtype, input logic [gpw_pkg::ADDR_W-1:0] va,
                             input logic [gpw_pkg::ADDR_W-1:0] ent);
        int gap;
        bit took;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_req_type        <= rtype;
        s_virtual_address <= va;
        s_entry_data      <= ent;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        predict_walk(rtype, va, ent);
    endtask

    // Drop valid, wait out every expected beat, then let ignored beats settle
    task automatic drain_walker();
        s_valid <= 1'b0;
        while (expected_walk_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_config(input logic pg, input logic pae,
                               input logic [gpw_pkg::ADDR_W-1:0] root);
        logic [gpw_pkg::ADDR_W-1:0] junk;
        drain_walker();
        junk = $urandom();
        cfg_wr_en <= 1'b1;
        cfg_index <= gpw_pkg::CFG_PAGING_ON;
        cfg_wdata <= {junk[31:1], pg};
        @(posedge aclk);
        junk = $urandom();
        cfg_index <= gpw_pkg::CFG_PAE_ON;
        cfg_wdata <= {junk[31:1], pae};
        @(posedge aclk);
        cfg_index <= gpw_pkg::CFG_TABLE_ROOT;
        cfg_wdata <= root;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_paging = pg;
        cfg_pae    = pae;
        cfg_root   = root;
        configs_loaded++;
    endtask

    function automatic logic [gpw_pkg::ADDR_W-1:0] random_entry();
        logic [gpw_pkg::ADDR_W-1:0] e;
        e = $urandom();
        e[gpw_pkg::PRESENT_BIT] = ($urandom_range(99) < 90);
        e[gpw_pkg::PS_BIT] = 1'($urandom_range(1));
        return e;
    endfunction

    function automatic logic [gpw_pkg::ADDR_W-1:0] random_address();
        case ($urandom_range(19))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_walk();
        int depth;
        send_beat(gpw_pkg::REQ_TRANSLATE, random_address(), $urandom());
        depth = 0;
        while (walk_busy && depth < 4) begin
            // leave some walks hanging so the next request restarts them
            if ($urandom_range(99) < 6) break;
            send_beat(gpw_pkg::REQ_ENTRY, $urandom(), random_entry());
            depth++;
        end
    endtask

    task automatic test_paging_off();
        load_config(1'b0, 1'b0, '1);
        send_beat(gpw_pkg::REQ_TRANSLATE, 32'h0000_0000, '1);
        send_beat(gpw_pkg::REQ_TRANSLATE, 32'hFFFF_FFFF, '0);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'hFFFF_FFFF);
    endtask

    task automatic test_legacy_walk();
        load_config(1'b1, 1'b0, '1);
        send_beat(gpw_pkg::REQ_TRANSLATE, 32'hFFFF_FFFF, '0);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'hFFFF_F001);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'hFFFF_FFFF);
        // 4MB page
        send_beat(gpw_pkg::REQ_TRANSLATE, 32'h1234_5678, '0);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'hFFC0_0081);
        send_beat(gpw_pkg::REQ_TRANSLATE, 32'h0000_0000, '0);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'hFFFF_FFFE);
    endtask

    task automatic test_pae_walk();
        load_config(1'b1, 1'b1, '1);
        send_beat(gpw_pkg::REQ_TRANSLATE, 32'hFFFF_FFFF, '0);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'hFFFF_F001);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'hFFE0_0081);
        send_beat(gpw_pkg::REQ_TRANSLATE, 32'h0000_0000, '1);
        send_beat(gpw_pkg::REQ_ENTRY, '1, 32'h0000_0001);
        send_beat(gpw_pkg::REQ_ENTRY, '1, 32'h0000_0001);
        send_beat(gpw_pkg::REQ_ENTRY, '1, 32'hFFFF_FFFE);
    endtask

    task automatic test_restart_and_stray();
        load_config(1'b1, 1'b1, '0);
        send_beat(gpw_pkg::REQ_TRANSLATE, 32'hC000_0000, '0);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'h0000_5001);
        send_beat(gpw_pkg::REQ_TRANSLATE, 32'h4020_1000, '0);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'h0000_0000);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'hFFFF_FFFF);
    endtask

    task automatic test_mode_switch();
        load_config(1'b1, 1'b0, 32'h0001_2000);
        send_beat(gpw_pkg::REQ_TRANSLATE, 32'h8765_4321, '0);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'h0000_1001);
        // walk continues as a PAE page directory
        load_config(1'b1, 1'b1, 32'h0001_2000);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'h0000_2001);
        // paging off only affects new requests; the leaf still resolves
        load_config(1'b0, 1'b0, 32'h0001_2000);
        send_beat(gpw_pkg::REQ_ENTRY, '0, 32'h0000_3001);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_beats);
        int start;
        int next_cfg;
        logic [gpw_pkg::ADDR_W-1:0] root;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = live_beats;
        next_cfg = 0;
        while (live_beats - start < n_beats) begin
            if (live_beats - start >= next_cfg) begin
                case ($urandom_range(9))
                    0: root = '0;
                    1: root = '1;
                    default: root = $urandom();
                endcase
                load_config($urandom_range(9) != 0, 1'($urandom_range(1)), root);
                next_cfg = live_beats - start + $urandom_range(50, 90);
            end
            case ($urandom_range(9))
                0: send_beat(gpw_pkg::REQ_ENTRY, $urandom(), random_entry());
                1: send_beat(gpw_pkg::REQ_TRANSLATE, random_address(), $urandom());
                default: random_walk();
            endcase
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_paging_off();
        test_legacy_walk();
        test_pae_walk();
        test_restart_and_stray();
        test_mode_switch();
        test_random_traffic(8, 55, 280);
        test_random_traffic(55, 8, 280);
        test_random_traffic(0, 0, 290);
        drain_walker();
        $display("Checked %0d results (%0d walks, %0d faults) from %0d live and %0d stray beats",
                 results_checked, walks_done, faults_seen, live_beats, ignored_beats);
        $display("Covered %0d register loads: legacy and PAE walks, large pages, restarts",
                 configs_loaded);
        if (mismatch_count == 0)
            $display("x86_guest_page_walker_tb OK");
        else
            $display("x86_guest_page_walker_tb NOT OK");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timeout with %0d results still expected", expected_walk_results.size());
        $display("x86_guest_page_walker_tb NOT OK");
        $finish;
    end

endmodule
